### rtl/wmfa_pkg.sv
`timescale 1ns / 1ps

package wmfa_pkg;

  localparam logic [15:0] CRC_POLY = 16'h3D65;

  // Depth of the queue between the front and back parts; must be a power of two.
  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    PH_AWAIT_L = 2'd0,
    PH_FIRST   = 2'd1,
    PH_DATA    = 2'd2
  } frame_phase_e;

  typedef enum logic [1:0] {
    IDX_DATA   = 2'd0,
    IDX_CRC_HI = 2'd1,
    IDX_CRC_LO = 2'd2
  } out_idx_e;

  // One classified input byte, as handed from the front part to the back part.
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        close_block;
    logic        frame_end;
    logic [15:0] crc_final;
  } entry_t;

  // CRC-16 update by one byte, MSB first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] d);
    logic [15:0] r;
    logic        fb;
    r = crc;
    for (int i = 0; i < 8; i++) begin
      fb = r[15] ^ d[7 - i];
      r  = {r[14:0], 1'b0};
      if (fb) begin
        r = r ^ CRC_POLY;
      end
    end
    return r;
  endfunction

endpackage

### rtl/wmfa_if.sv
`timescale 1ns / 1ps

interface wmfa_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface wmfa_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_crc;
  logic       frame_end;
  logic       last_of_run;

  modport source (output valid, output out_byte, output is_crc, output frame_end,
                  output last_of_run, input ready);
  modport sink (input valid, input out_byte, input is_crc, input frame_end,
                input last_of_run, output ready);
endinterface

### rtl/wmbus_format_a_crc_framer.sv
// Results are offered from the back part's output register, behind the queue.
// Throughput: one item per cycle while the queue is not full; an item that closes a
// block yields three results (byte, CRC high, CRC low) before it leaves the queue.
// A two-entry queue between the classifying front part and the emitting back
// part lets the input keep flowing while the output is stalled.
// Reset (rst_ni low, asynchronous) empties the queue and waits for an L field.
`timescale 1ns / 1ps

module wmbus_format_a_crc_framer
  import wmfa_pkg::*;
#(
  parameter int unsigned BLOCK_LEN        = 16,
  parameter int unsigned FIRST_BLOCK_DATA = 9
) (
  input  logic clk_i,
  input  logic rst_ni,
  wmfa_in_if.sink    in_i,
  wmfa_out_if.source out_o
);

  entry_t front_entry;
  entry_t head;
  logic   push;
  logic   pop;
  logic   full;
  logic   empty;
  logic   full_next;
  logic   in_ready;

  // The front part classifies every accepted byte at once: it updates the CRC,
  // counts the block and the remaining data bytes, and marks whether the byte
  // closes a block and whether that block ends the frame.
  assign in_i.ready = in_ready;
  assign push       = in_i.valid && in_ready;

  wmfa_front #(
    .BLOCK_LEN        (BLOCK_LEN),
    .FIRST_BLOCK_DATA (FIRST_BLOCK_DATA)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .data_byte_i (in_i.data_byte),
    .entry_o     (front_entry)
  );

  wmfa_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .wr_data_i (front_entry),
    .pop_i     (pop),
    .rd_data_o (head),
    .full_o    (full),
    .empty_o   (empty)
  );

  // The input is held off for as long as the queue is full; the flag register
  // is loaded with the queue's fill state as of the next edge, so it tracks the
  // queue exactly and no item can overrun it.
  assign full_next = (full && !pop) || (push && !pop && !empty && !full);

  wmfa_rdy u_rdy (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .full_d_i (full_next),
    .ready_o  (in_ready)
  );

  // The back part walks the head entry, emitting the echoed byte and, when the
  // entry closes a block, the two inverted CRC bytes after it.
  wmfa_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .empty_i (empty),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

### rtl/wmfa_front.sv
`timescale 1ns / 1ps

module wmfa_front
  import wmfa_pkg::*;
#(
  parameter int unsigned BLOCK_LEN        = 16,
  parameter int unsigned FIRST_BLOCK_DATA = 9
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  logic [7:0] data_byte_i,
  output entry_t     entry_o
);

  localparam int unsigned MaxCnt = (BLOCK_LEN > FIRST_BLOCK_DATA) ? BLOCK_LEN
                                                                  : FIRST_BLOCK_DATA;
  localparam int unsigned CntW   = $clog2(MaxCnt + 1);

  frame_phase_e      phase_q, phase_d;
  logic [15:0]       crc_q, crc_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [7:0]        left_q, left_d;

  logic [15:0]       crc_new;
  logic [CntW-1:0]   cnt_new;
  logic [7:0]        left_new;
  logic              close_blk;
  logic              end_frame;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_AWAIT_L;
      crc_q   <= '0;
      cnt_q   <= '0;
      left_q  <= '0;
    end else if (push_i) begin
      phase_q <= phase_d;
      crc_q   <= crc_d;
      cnt_q   <= cnt_d;
      left_q  <= left_d;
    end
  end

  always_comb begin
    crc_new   = crc_byte(crc_q, data_byte_i);
    cnt_new   = cnt_q + CntW'(1);
    left_new  = left_q;
    close_blk = 1'b0;
    end_frame = 1'b0;
    phase_d   = phase_q;
    crc_d     = crc_new;
    cnt_d     = cnt_new;
    left_d    = left_q;

    unique case (phase_q)
      PH_FIRST: begin
        if (cnt_new >= CntW'(FIRST_BLOCK_DATA)) begin
          close_blk = 1'b1;
          end_frame = (left_q == 8'd0);
        end
      end
      PH_DATA: begin
        if (left_q != 8'd0) begin
          left_new = left_q - 8'd1;
        end
        left_d = left_new;
        if ((cnt_new >= CntW'(BLOCK_LEN)) || (left_new == 8'd0)) begin
          close_blk = 1'b1;
          end_frame = (left_new == 8'd0);
        end
      end
      default: begin
        // The L field opens a frame; an L of at most the first block's data length ends it there.
        crc_d   = crc_byte(16'h0000, data_byte_i);
        left_d  = (data_byte_i > 8'(FIRST_BLOCK_DATA)) ?
                  (data_byte_i - 8'(FIRST_BLOCK_DATA)) : 8'd0;
        cnt_d   = '0;
        phase_d = PH_FIRST;
      end
    endcase

    if (close_blk) begin
      crc_d   = '0;
      cnt_d   = '0;
      phase_d = end_frame ? PH_AWAIT_L : PH_DATA;
    end

    entry_o.data_byte   = data_byte_i;
    entry_o.close_block = close_blk;
    entry_o.frame_end   = end_frame;
    entry_o.crc_final   = ~crc_new;
  end

endmodule

### rtl/wmfa_fifo.sv
`timescale 1ns / 1ps

module wmfa_fifo
  import wmfa_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t wr_data_i,
  input  logic   pop_i,
  output entry_t rd_data_o,
  output logic   full_o,
  output logic   empty_o
);

  entry_t                mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_CNT_W-1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + FIFO_CNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - FIFO_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  assign rd_data_o = mem_q[rd_ptr_q];
  assign full_o    = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign empty_o   = (cnt_q == '0);

endmodule

### rtl/wmfa_back.sv
`timescale 1ns / 1ps

module wmfa_back
  import wmfa_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  entry_t head_i,
  input  logic   empty_i,
  output logic   pop_o,
  wmfa_out_if.source out_o
);

  out_idx_e   idx_q, idx_d;
  logic       vld_q;
  logic [7:0] byte_q, byte_d;
  logic       crc_q, crc_d;
  logic       end_q, end_d;
  logic       last_q, last_d;
  logic       load;

  // The output register may be refilled when it is empty or being taken.
  assign load  = !empty_i && (!vld_q || out_o.ready);
  assign pop_o = load && last_d;

  always_comb begin
    byte_d = head_i.data_byte;
    crc_d  = 1'b0;
    end_d  = 1'b0;
    last_d = 1'b1;
    idx_d  = idx_q;
    unique case (idx_q)
      IDX_CRC_HI: begin
        byte_d = head_i.crc_final[15:8];
        crc_d  = 1'b1;
        last_d = 1'b0;
        idx_d  = IDX_CRC_LO;
      end
      IDX_CRC_LO: begin
        byte_d = head_i.crc_final[7:0];
        crc_d  = 1'b1;
        end_d  = head_i.frame_end;
        idx_d  = IDX_DATA;
      end
      default: begin
        last_d = !head_i.close_block;
        idx_d  = head_i.close_block ? IDX_CRC_HI : IDX_DATA;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= IDX_DATA;
    end else begin
      if (load) begin
        vld_q <= 1'b1;
        idx_q <= idx_d;
      end else if (out_o.ready) begin
        vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= byte_d;
      crc_q  <= crc_d;
      end_q  <= end_d;
      last_q <= last_d;
    end
  end

  assign out_o.valid       = vld_q;
  assign out_o.out_byte    = byte_q;
  assign out_o.is_crc      = crc_q;
  assign out_o.frame_end   = end_q;
  assign out_o.last_of_run = last_q;

endmodule

### rtl/wmfa_if_top_note.sv
`timescale 1ns / 1ps

// Registered stall flag for the input side: kept as its own small stage so the
// input ready is a pure flop output and never depends on the output ready.
module wmfa_rdy
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic full_d_i,
  output logic ready_o
);

  logic full_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else begin
      full_q <= full_d_i;
    end
  end

  assign ready_o = !full_q;

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps

// Self-checking bench for the wireless M-Bus format A framer. Bytes go in one
// item at a time. A scoreboard model of the framer predicts every echoed byte
// and every inserted CRC byte, and the monitor checks each output item against
// the oldest prediction.
module tb_top;
  import wmfa_pkg::*;

  localparam int unsigned BLOCK_LEN  = 16;
  localparam int unsigned FIRST_DATA = 9;
  localparam int unsigned RANDOM_ITEMS = 140;
  localparam int unsigned HOLD_CYCLES  = 80;
  localparam int unsigned MAX_REPORTS  = 10;

  // L values around the block boundaries: short, exact first block, one past,
  // one full later block, a one-byte tail, and two full later blocks.
  localparam int unsigned BOUNDARY_LENS [9] = '{0, 8, 9, 10, 24, 25, 26, 41, 42};

  // One output item as the framer should present it.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_crc;
    logic       frame_end;
    logic       last_of_run;
  } framed_byte_t;

  // One row of the directed table. Rows with a typed result carry it in
  // want; the other rows are checked against the model alone.
  typedef struct packed {
    logic [7:0]   data;
    logic         typed;
    framed_byte_t want;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  wmfa_in_if  in_bus ();
  wmfa_out_if out_bus ();

  wmbus_format_a_crc_framer #(
    .BLOCK_LEN       (BLOCK_LEN),
    .FIRST_BLOCK_DATA(FIRST_DATA)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  always #4 clk_i = ~clk_i;

  // Shadow state of the framer, kept by the scoreboard model.
  logic [15:0]  crc_run;
  int unsigned  block_fill;
  logic [7:0]   bytes_left;
  frame_phase_e frame_phase;

  // Bytes still owed by the framer, oldest first.
  framed_byte_t expected_bytes [$];

  int unsigned fault_count;
  int unsigned results_seen;
  int unsigned items_sent;
  int unsigned blocks_closed;
  int unsigned frames_done;
  int unsigned longest_len;

  // Sender pacing and the one long receiver hold-off.
  int unsigned burst_left;
  bit          hold_request;
  int unsigned hold_left;
  bit          hold_done;

  // The directed part: two complete frames. The first has a short L field of
  // zero, so it is the first block alone and its L byte is echoed as zero. The
  // second has L = 10, so one data byte trails in a block of its own and ends
  // the frame. The data bytes sweep the extremes of the byte.
  stim_row_t directed_rows [21] = '{
    '{8'h00, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b1}},
    '{8'h00, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'h80, 1'b0, '0},
    '{8'h01, 1'b0, '0}, '{8'h7F, 1'b0, '0}, '{8'hAA, 1'b0, '0},
    '{8'h55, 1'b0, '0}, '{8'hFE, 1'b0, '0}, '{8'h00, 1'b0, '0},
    '{8'h0A, 1'b1, '{8'h0A, 1'b0, 1'b0, 1'b1}},
    '{8'h13, 1'b0, '0}, '{8'h57, 1'b0, '0}, '{8'h9B, 1'b0, '0},
    '{8'hDF, 1'b0, '0}, '{8'h24, 1'b0, '0}, '{8'h68, 1'b0, '0},
    '{8'hAC, 1'b0, '0}, '{8'hE0, 1'b0, '0}, '{8'hF1, 1'b0, '0},
    '{8'h3C, 1'b0, '0}
  };

  // CRC-16 over one byte, most significant bit first.
  function automatic logic [15:0] crc_step(input logic [15:0] acc, input logic [7:0] data);
    logic [15:0] shift_reg;
    logic [7:0]  shift_in;
    logic        feedback;
    shift_reg = acc;
    shift_in  = data;
    repeat (8) begin
      feedback  = shift_reg[15] ^ shift_in[7];
      shift_reg = shift_reg << 1;
      if (feedback) begin
        shift_reg = shift_reg ^ CRC_POLY;
      end
      shift_in = shift_in << 1;
    end
    return shift_reg;
  endfunction

  // Advances the shadow framer by one accepted byte and returns the output
  // items that byte causes: one for a plain byte, three when it closes a block.
  function automatic int frame_byte(input logic [7:0] data, output framed_byte_t res [3]);
    logic        close_blk;
    logic        frame_done;
    logic [15:0] crc_out;
    close_blk  = 1'b0;
    frame_done = 1'b0;
    if (frame_phase != PH_FIRST && frame_phase != PH_DATA) begin
      // A new L field. A short one still leaves a full first block to come.
      crc_run     = crc_step(16'h0000, data);
      bytes_left  = (data > FIRST_DATA) ? 8'(data - FIRST_DATA) : 8'd0;
      block_fill  = 0;
      frame_phase = PH_FIRST;
      if (data > longest_len) begin
        longest_len = data;
      end
      res[0] = '{data, 1'b0, 1'b0, 1'b1};
      return 1;
    end
    crc_run    = crc_step(crc_run, data);
    block_fill = block_fill + 1;
    if (frame_phase == PH_FIRST) begin
      if (block_fill >= FIRST_DATA) begin
        close_blk  = 1'b1;
        frame_done = (bytes_left == 8'd0);
      end
    end else begin
      if (bytes_left > 8'd0) begin
        bytes_left = bytes_left - 8'd1;
      end
      if (block_fill >= BLOCK_LEN || bytes_left == 8'd0) begin
        close_blk  = 1'b1;
        frame_done = (bytes_left == 8'd0);
      end
    end
    if (!close_blk) begin
      res[0] = '{data, 1'b0, 1'b0, 1'b1};
      return 1;
    end
    // The block closes: the byte itself, then the inverted CRC, high byte first.
    crc_out = ~crc_run;
    res[0] = '{data, 1'b0, 1'b0, 1'b0};
    res[1] = '{crc_out[15:8], 1'b1, 1'b0, 1'b0};
    res[2] = '{crc_out[7:0], 1'b1, frame_done, 1'b1};
    crc_run     = 16'h0000;
    block_fill  = 0;
    frame_phase = frame_done ? PH_AWAIT_L : PH_DATA;
    blocks_closed = blocks_closed + 1;
    if (frame_done) begin
      frames_done = frames_done + 1;
    end
    return 3;
  endfunction

  // Offers one byte and holds it until the framer takes it. At the accepting
  // edge the model runs, and either its results or the typed result of a
  // directed row are queued.
  task automatic offer_byte(input logic [7:0] data, input logic typed, input framed_byte_t want);
    framed_byte_t res [3];
    int           count;
    in_bus.valid     <= 1'b1;
    in_bus.data_byte <= data;
    do @(posedge clk_i); while (!in_bus.ready);
    count = frame_byte(data, res);
    if (typed) begin
      expected_bytes.push_back(want);
    end else begin
      for (int i = 0; i < count; i++) begin
        expected_bytes.push_back(res[i]);
      end
    end
    items_sent = items_sent + 1;
  endtask

  // Sender pacing: bursts of random length with idle gaps between them. While
  // the receiver is held off the sender keeps offering, so the queue inside
  // the framer fills and its input stalls.
  task automatic pace_sender();
    int unsigned gap;
    if (hold_request || hold_left > 0) begin
      return;
    end
    if (burst_left > 0) begin
      burst_left = burst_left - 1;
      return;
    end
    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
    gap = $urandom_range(1, 7);
    in_bus.valid <= 1'b0;
    repeat (gap) @(posedge clk_i);
  endtask

  // Receiver: a rotating stall pattern, renewed whenever its age count runs out. Some
  // patterns are all ones, which gives stretches with no stall at all. A hold-off
  // request overrides the pattern and holds ready low until its countdown ends.
  logic [15:0] stall_pattern;
  int unsigned pattern_age;

  always @(posedge clk_i) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left     = hold_left - 1;
      hold_done     = 1'b1;
      out_bus.ready <= 1'b0;
    end else begin
      if (pattern_age == 0) begin
        stall_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom | $urandom);
        pattern_age   = 48;
      end
      pattern_age   = pattern_age - 1;
      out_bus.ready <= stall_pattern[0];
      stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
    end
  end

  // Monitor: every output item taken is compared, field by field, with the
  // oldest prediction.
  always @(posedge clk_i) begin
    framed_byte_t got;
    framed_byte_t want;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      got = '{out_bus.out_byte, out_bus.is_crc, out_bus.frame_end, out_bus.last_of_run};
      if (expected_bytes.size() == 0) begin
        fault_count = fault_count + 1;
        if (fault_count <= MAX_REPORTS) begin
          $display("output item %0d not predicted: byte %02h crc %0b end %0b last %0b",
                   results_seen, got.out_byte, got.is_crc, got.frame_end, got.last_of_run);
        end
      end else begin
        want = expected_bytes.pop_front();
        if (got.out_byte !== want.out_byte || got.is_crc !== want.is_crc ||
            got.frame_end !== want.frame_end || got.last_of_run !== want.last_of_run) begin
          fault_count = fault_count + 1;
          if (fault_count <= MAX_REPORTS) begin
            $display("output item %0d: expected %02h/%0b/%0b/%0b, got %02h/%0b/%0b/%0b",
                     results_seen, want.out_byte, want.is_crc, want.frame_end,
                     want.last_of_run, got.out_byte, got.is_crc, got.frame_end,
                     got.last_of_run);
          end
        end
      end
      results_seen = results_seen + 1;
    end
  end

  // Main sequence: reset, directed frames, random frames, drain, verdict.
  initial begin
    int unsigned random_items;
    int unsigned hold_at;
    int unsigned len;
    int unsigned data_count;
    int unsigned pick;

    in_bus.valid     = 1'b0;
    in_bus.data_byte = 8'h00;
    out_bus.ready    = 1'b0;
    crc_run       = 16'h0000;
    block_fill    = 0;
    bytes_left    = 8'd0;
    frame_phase   = PH_AWAIT_L;
    fault_count   = 0;
    results_seen  = 0;
    items_sent    = 0;
    blocks_closed = 0;
    frames_done   = 0;
    longest_len   = 0;
    burst_left    = 0;
    hold_request  = 1'b0;
    hold_left     = 0;
    hold_done     = 1'b0;
    stall_pattern = 16'hFFFF;
    pattern_age   = 0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      offer_byte(directed_rows[i].data, directed_rows[i].typed, directed_rows[i].want);
      pace_sender();
    end

    // Random frames: well-formed frames with random content. The L field is
    // mostly small, now and then a block boundary, and rarely a long frame
    // early in the run. Each frame is completed, so the run ends between frames.
    random_items = 0;
    hold_at      = $urandom_range(20, 100);
    while (random_items < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 19);
      if (pick < 4) begin
        len = BOUNDARY_LENS[$urandom_range(0, 8)];
      end else if (pick == 19 && random_items < 40) begin
        len = $urandom_range(49, 120);
      end else begin
        len = $urandom_range(0, 48);
      end
      data_count = (len > FIRST_DATA) ? len : FIRST_DATA;
      offer_byte(8'(len), 1'b0, '0);
      random_items = random_items + 1;
      pace_sender();
      repeat (data_count) begin
        if (!hold_done && random_items >= hold_at) begin
          hold_request = 1'b1;
        end
        offer_byte(8'($urandom), 1'b0, '0);
        random_items = random_items + 1;
        pace_sender();
      end
    end

    // A valid that is still high from the last item is dropped here; pacing
    // never lowers it in this same step, since offer_byte returned at the edge.
    in_bus.valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk_i);
    // Any extra output items are still checked while the bench waits before the verdict.
    repeat (8) @(posedge clk_i);

    $display("Sent %0d items in %0d frames with %0d CRC blocks; longest L field %0d.",
             items_sent, frames_done, blocks_closed, longest_len);
    $display("Checked %0d output items, including one %0d-cycle receiver hold-off.",
             results_seen, HOLD_CYCLES);
    if (fault_count == 0 && expected_bytes.size() == 0) begin
      $display("wmbus_format_a_crc_framer regression: pass");
    end else begin
      $display("%0d failures, %0d output items never arrived.",
               fault_count, expected_bytes.size());
      $display("wmbus_format_a_crc_framer regression: fail");
    end
    $finish;
  end

  // Watchdog: far longer than the slowest correct run.
  initial begin
    #2000000;
    $display("Timed out with %0d output items still owed.", expected_bytes.size());
    $display("wmbus_format_a_crc_framer regression: fail");
    $finish;
  end

endmodule
